// ===== rtl/core/scsr_pkg.sv =====
// types, constants and helpers shared by the stencil row assembler
// no dependencies
`default_nettype none
package scsr_pkg;

  localparam int CFG_W = 11;
  localparam int KW    = 32;
  localparam int COL_W = 30;
  localparam int VAL_W = 36;
  localparam int POS_W = 33;
  localparam int REG_W = 2;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_SIZE_SLOW = 2'd0;
  localparam logic [REG_W-1:0] REG_SIZE_MID  = 2'd1;
  localparam logic [REG_W-1:0] REG_SIZE_FAST = 2'd2;

  typedef struct packed {
    logic [KW-1:0] kz_here;
    logic [KW-1:0] kz_below;
    logic [KW-1:0] kz_above;
    logic [KW-1:0] ky_here;
    logic [KW-1:0] ky_below;
    logic [KW-1:0] ky_above;
    logic [KW-1:0] kx_here;
    logic [KW-1:0] kx_below;
    logic [KW-1:0] kx_above;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]        col_index;
    logic signed [VAL_W-1:0] entry_value;
    logic [POS_W-1:0]        entry_position;
    logic                    row_end;
  } out_item_t;

  // neighbour directions in row order
  typedef enum logic [2:0] {
    DIR_ZM, DIR_ZP, DIR_YM, DIR_YP, DIR_XM, DIR_XP, DIR_DONE
  } dir_t;

  // classified cell handed from front to back
  typedef struct packed {
    in_item_t         k;
    logic [5:0]       nbr;
    logic             zbound;
    logic             grid_end;
    logic [COL_W-1:0] self_idx;
    logic [COL_W-1:0] stride_mid;
    logic [COL_W-1:0] stride_slow;
  } task_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL1, F_MUL2, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_SCAN, B_LOAD, B_DIV, B_EMIT} back_state_t;

  // column index of a neighbour entry, modulo 2^30
  function automatic logic [COL_W-1:0] col_of(input logic [COL_W-1:0] self_idx,
                                               input logic [COL_W-1:0] s_mid,
                                               input logic [COL_W-1:0] s_slow,
                                               input dir_t d);
    logic [COL_W-1:0] c;
    unique case (d)
      DIR_ZM:  c = self_idx - COL_W'(1);
      DIR_ZP:  c = self_idx + COL_W'(1);
      DIR_YM:  c = self_idx - s_mid;
      DIR_YP:  c = self_idx + s_mid;
      DIR_XM:  c = self_idx - s_slow;
      DIR_XP:  c = self_idx + s_slow;
      default: c = self_idx;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/scsr_front.sv =====
// front: accepts cells, tracks grid coordinates, classifies neighbours
// and computes the row index; depends on scsr_pkg
`default_nettype none
module scsr_front import scsr_pkg::*; #(
  parameter int MAX_AXIS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire in_item_t         in_item,
  input  wire logic [CFG_W-1:0] size_slow,
  input  wire logic [CFG_W-1:0] size_mid,
  input  wire logic [CFG_W-1:0] size_fast,
  output logic                  q_push,
  input  wire logic             q_full,
  output task_t                 q_data
);

  localparam int AW = (MAX_AXIS > 2) ? $clog2(MAX_AXIS) : 1;
  localparam int SW = AW + 1;

  front_state_t st, st_next;
  task_t tk;
  logic [AW-1:0] pos_slow, pos_mid, pos_fast;
  logic [AW-1:0] xr, yr, zr;
  logic [SW-1:0] nm_r, nf_r;
  logic [COL_W-1:0] xm;
  logic [SW-1:0] ns, nm, nf;
  logic x_more, y_more, z_more, accept;

  // size clamp: zero acts as one, large values as the axis limit
  function automatic logic [SW-1:0] eff(input logic [CFG_W-1:0] v);
    logic [SW-1:0] r;
    if (v == '0) r = SW'(1);
    else if (int'(v) > MAX_AXIS) r = SW'(MAX_AXIS);
    else r = SW'(v);
    return r;
  endfunction

  assign ns = eff(size_slow);
  assign nm = eff(size_mid);
  assign nf = eff(size_fast);

  // neighbour presence on the far side of each axis
  assign z_more = (SW'(pos_fast) + SW'(1)) < nf;
  assign y_more = (SW'(pos_mid) + SW'(1)) < nm;
  assign x_more = (SW'(pos_slow) + SW'(1)) < ns;

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      F_IDLE: if (push) st_next = F_MUL1;
      F_MUL1: st_next = F_MUL2;
      F_MUL2: st_next = F_PUSH;
      F_PUSH: if (!q_full) st_next = F_IDLE;
      default: st_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full   = (st != F_IDLE);
    accept = (st == F_IDLE) && push;
    q_push = (st == F_PUSH) && !q_full;
  end

  assign q_data = tk;

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= F_IDLE;
      pos_slow <= '0;
      pos_mid  <= '0;
      pos_fast <= '0;
    end else begin
      st <= st_next;
      // coordinate advance in index order
      if (accept) begin
        if (z_more) begin
          pos_fast <= AW'(SW'(pos_fast) + SW'(1));
        end else begin
          pos_fast <= '0;
          if (y_more) begin
            pos_mid <= AW'(SW'(pos_mid) + SW'(1));
          end else begin
            pos_mid <= '0;
            if (x_more) pos_slow <= AW'(SW'(pos_slow) + SW'(1));
            else pos_slow <= '0;
          end
        end
      end
    end
  end

  // classification and row index
  always_ff @(posedge clk) begin
    if (accept) begin
      tk.k        <= in_item;
      tk.nbr      <= {x_more, (pos_slow != '0), y_more, (pos_mid != '0),
                      z_more, (pos_fast != '0)};
      tk.zbound   <= (pos_fast == '0) || (SW'(pos_fast) == nf - SW'(1));
      tk.grid_end <= !z_more && !y_more && !x_more;
      xr <= pos_slow;
      yr <= pos_mid;
      zr <= pos_fast;
      nm_r <= nm;
      nf_r <= nf;
    end
    if (st == F_MUL1) begin
      xm             <= COL_W'(xr) * COL_W'(nm_r) + COL_W'(yr);
      tk.stride_slow <= COL_W'(nm_r) * COL_W'(nf_r);
      tk.stride_mid  <= COL_W'(nf_r);
    end
    if (st == F_MUL2) begin
      tk.self_idx <= xm * COL_W'(nf_r) + COL_W'(zr);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/scsr_queue.sv =====
// two-entry queue of classified cells between front and back
// depends on scsr_pkg
`default_nettype none
module scsr_queue import scsr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_push,
  input  wire task_t q_wdata,
  output logic       q_full,
  input  wire logic  q_pop,
  output logic       q_empty,
  output task_t      q_rdata
);

  task_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign q_full  = (cnt == 2'd2);
  assign q_empty = (cnt == 2'd0);
  assign q_rdata = mem[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (q_push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      case ({q_push, q_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (q_push) mem[wp] <= q_wdata;
  end

endmodule
`default_nettype wire

// ===== rtl/core/scsr_back.sv =====
// back: harmonic means through a shared bit-serial divider, diagonal sum,
// and entry emission with running positions; depends on scsr_pkg
`default_nettype none
module scsr_back import scsr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  wire task_t q_rdata,
  output logic       q_pop,
  output logic       empty,
  input  wire logic  pop,
  output out_item_t  out_item
);

  back_state_t st, st_next;
  task_t tk;
  dir_t dir;
  logic [2:0] n, e, e_m1;
  logic [4:0] bcnt;
  logic [2*KW-1:0] p;
  logic [KW:0] s, rem, rem_n;
  logic [KW-1:0] qd, qd_n, mean_n;
  logic [KW:0] t_hi;
  logic [KW+1:0] t;
  logic ge;
  logic [VAL_W-1:0] diag;
  logic [KW-1:0] meanq [6];
  dir_t dirq [6];
  logic [POS_W-1:0] entries;
  logic ov, load, present;
  logic [KW-1:0] a_op, b_op;

  // operand pair for the current direction
  always_comb begin
    case (dir)
      DIR_ZM:  begin a_op = tk.k.kz_here; b_op = tk.k.kz_below; end
      DIR_ZP:  begin a_op = tk.k.kz_here; b_op = tk.k.kz_above; end
      DIR_YM:  begin a_op = tk.k.ky_here; b_op = tk.k.ky_below; end
      DIR_YP:  begin a_op = tk.k.ky_here; b_op = tk.k.ky_above; end
      DIR_XM:  begin a_op = tk.k.kx_here; b_op = tk.k.kx_below; end
      DIR_XP:  begin a_op = tk.k.kx_here; b_op = tk.k.kx_above; end
      default: begin a_op = '0; b_op = '0; end
    endcase
  end

  assign present = (dir != DIR_DONE) && tk.nbr[dir];

  // one restoring step of floor(2ab/(a+b))
  always_comb begin
    t_hi   = rem;
    t      = {t_hi, qd[KW-1]};
    ge     = t >= {1'b0, s};
    rem_n  = ge ? (KW+1)'(t - {1'b0, s}) : t[KW:0];
    qd_n   = {qd[KW-2:0], ge};
    mean_n = (s == '0) ? '0 : qd_n;
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      B_IDLE: if (!q_empty) st_next = B_SCAN;
      B_SCAN: begin
        if (dir == DIR_DONE) st_next = B_EMIT;
        else if (present) st_next = B_LOAD;
      end
      B_LOAD: st_next = B_DIV;
      B_DIV:  if (bcnt == 5'd31) st_next = B_SCAN;
      B_EMIT: if (load && e == n) st_next = B_IDLE;
      default: st_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = (st == B_IDLE) && !q_empty;
    load  = (st == B_EMIT) && (!ov || pop);
    empty = !ov;
  end

  assign e_m1 = e - 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= B_IDLE;
      ov      <= 1'b0;
      entries <= '0;
    end else begin
      st <= st_next;
      if (load) ov <= 1'b1;
      else if (pop) ov <= 1'b0;
      // running position, cleared at the end of the grid
      if (load && e == n) begin
        if (tk.grid_end) entries <= '0;
        else entries <= entries + POS_W'(n) + POS_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st)
      B_IDLE: begin
        tk   <= q_rdata;
        dir  <= DIR_ZM;
        n    <= '0;
        e    <= '0;
        diag <= q_rdata.zbound ? VAL_W'({q_rdata.k.kz_here, 1'b0}) : '0;
      end
      B_SCAN: begin
        p <= (2*KW)'(a_op) * (2*KW)'(b_op);
        s <= {1'b0, a_op} + {1'b0, b_op};
        if (!present && dir != DIR_DONE) dir <= dir_t'(dir + 3'd1);
      end
      B_LOAD: begin
        rem  <= p[2*KW-1:KW-1];
        qd   <= {p[KW-2:0], 1'b0};
        bcnt <= '0;
      end
      B_DIV: begin
        rem  <= rem_n;
        qd   <= qd_n;
        bcnt <= bcnt + 5'd1;
        if (bcnt == 5'd31) begin
          meanq[n] <= mean_n;
          dirq[n]  <= dir;
          diag     <= diag + VAL_W'(mean_n);
          n        <= n + 3'd1;
          dir      <= dir_t'(dir + 3'd1);
        end
      end
      B_EMIT: begin
        if (load) e <= e + 3'd1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_item.entry_position <= entries + POS_W'(e);
      out_item.row_end        <= (e == n);
      if (e == '0) begin
        out_item.col_index   <= tk.self_idx;
        out_item.entry_value <= diag;
      end else begin
        out_item.col_index   <= col_of(tk.self_idx, tk.stride_mid, tk.stride_slow,
                                       dirq[e_m1]);
        out_item.entry_value <= '0 - VAL_W'(meanq[e_m1]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/seven_point_stencil_csr_assembler_core.sv =====
// Seven-point stencil CSR row assembler, top level. Front: one cell at a time
// through accept, two multiply steps and queue push, waiting while the queue is
// full. Back: per cell, a direction scan and one harmonic mean for each in-grid
// neighbour; the 32-step shared divider sets the rate unless results stall.
// Synchronous reset clears coordinates, position count and the cell queue;
// size registers reset to 1. Depends on scsr_pkg and the front/queue/back.
`default_nettype none
module seven_point_stencil_csr_assembler_core import scsr_pkg::*; #(
  parameter int MAX_AXIS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire in_item_t         in_item,
  output logic                  empty,
  input  wire logic             pop,
  output out_item_t             out_item,
  input  wire logic             wr_en,
  input  wire logic [REG_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0] wr_data
);

  logic [CFG_W-1:0] size_slow, size_mid, size_fast;
  logic q_push, q_full, q_pop, q_empty;
  task_t q_wdata, q_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_slow <= CFG_W'(1);
      size_mid  <= CFG_W'(1);
      size_fast <= CFG_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_SIZE_SLOW: size_slow <= wr_data;
        REG_SIZE_MID:  size_mid  <= wr_data;
        REG_SIZE_FAST: size_fast <= wr_data;
        default: ;
      endcase
    end
  end

  scsr_front #(.MAX_AXIS(MAX_AXIS)) u_front (
    .clk, .rst, .push, .full, .in_item,
    .size_slow, .size_mid, .size_fast,
    .q_push, .q_full, .q_data(q_wdata)
  );

  scsr_queue u_queue (
    .clk, .rst, .q_push, .q_wdata, .q_full, .q_pop, .q_empty, .q_rdata
  );

  scsr_back u_back (
    .clk, .rst, .q_empty, .q_rdata, .q_pop, .empty, .pop, .out_item
  );

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("cell queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("cell queue underflow");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full)) else $error("not idle after reset");

endmodule
`default_nettype wire
